@@ rtl/mcw_pkg.sv @@
package mcw_pkg;

    localparam int MAX_TEXT = 1024;
    localparam int ALPHABET = 128;

    localparam int CH_W   = 7;
    localparam int CODE_W = $clog2(ALPHABET);
    localparam int TXT_AW = $clog2(MAX_TEXT);
    localparam int CNT_W  = $clog2(MAX_TEXT + 1);
    localparam int NEED_W = 12;
    localparam int MISS_W = 8;

    typedef logic signed [NEED_W-1:0] t_need;
    typedef logic [CODE_W-1:0]        t_code;

    localparam t_need NEED_MAX = t_need'(2047);

    localparam logic OP_PAT  = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_CHK,
        S_RDTXT,
        S_REM,
        S_DONE
    } t_state;

    // one read and one write port on the need store, plus a job-end clear
    typedef struct packed {
        logic  rd_en;
        t_code rd_addr;
        logic  wr_en;
        t_code wr_addr;
        t_need wr_data;
        logic  clr;
    } t_need_req;

    // fold a character code onto the alphabet
    function automatic t_code to_code(input logic [CH_W-1:0] ch);
        return ch[CODE_W-1:0];
    endfunction

endpackage

@@ rtl/mcw_need_alu.sv @@
module mcw_need_alu (
    input  mcw_pkg::t_need i_old,
    input  logic           i_inc,
    output mcw_pkg::t_need o_new,
    output logic           o_old_zero,
    output logic           o_new_zero
);
    import mcw_pkg::*;

    // increment saturates at the top of the range; decrement never reaches the bottom
    always_comb begin
        if (i_inc) begin
            o_new = (i_old < NEED_MAX) ? i_old + t_need'(1) : i_old;
        end else begin
            o_new = i_old - t_need'(1);
        end
        o_old_zero = (i_old == '0);
        o_new_zero = (o_new == '0);
    end

endmodule

@@ rtl/mcw_need_ram.sv @@
module mcw_need_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mcw_pkg::t_need_req i_req,
    output mcw_pkg::t_need     o_rd_data
);
    import mcw_pkg::*;

    t_need               r_mem [ALPHABET];
    logic [ALPHABET-1:0] r_vld;
    t_need               r_rd;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    // entry not written since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

@@ rtl/mcw_text_ram.sv @@
module mcw_text_ram (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [mcw_pkg::TXT_AW-1:0]  i_wr_addr,
    input  mcw_pkg::t_code              i_wr_data,
    input  logic                        i_rd_en,
    input  logic [mcw_pkg::TXT_AW-1:0]  i_rd_addr,
    output mcw_pkg::t_code              o_rd_data
);
    import mcw_pkg::*;

    t_code r_mem [MAX_TEXT];
    t_code r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

@@ rtl/min_covering_window.sv @@
// Shortest covering window. Send the pattern characters (op 0), then the text
// characters (op 1); the text character with last set ends the job, yields one
// result word (found, start, length, overflow) and clears all state for the next
// job. Text beyond 1024 characters is dropped and flagged. All need counts live
// in one read-modify-write store fed by one shared +/-1 unit, so each kept word
// is read and updated; a text word is then checked, with a text read, update and
// re-check per left-end removal it triggers (removals never exceed the number of
// text words), then a done step, where a dropped one goes straight. The block
// takes no word while busy; a finished result waits in the output register, and
// only the next job's last text word stalls until that result has been taken.
module min_covering_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [mcw_pkg::CH_W-1:0]    i_ch,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_found,
    output logic [mcw_pkg::TXT_AW-1:0]  o_start_res,
    output logic [mcw_pkg::CNT_W-1:0]   o_length,
    output logic                        o_overflow
);
    import mcw_pkg::*;

    t_state r_state, n_state;

    logic               r_op;
    logic               r_last;
    t_code              r_code;
    logic [MISS_W-1:0]  r_missing;
    logic [CNT_W-1:0]   r_right;
    logic [CNT_W-1:0]   r_left;
    logic [TXT_AW-1:0]  r_best_start;
    logic [CNT_W-1:0]   r_best_len;
    logic               r_have_best;
    logic               r_ovf;
    logic               r_pat_seen;

    logic               r_o_valid;
    logic               r_o_found;
    logic [TXT_AW-1:0]  r_o_start;
    logic [CNT_W-1:0]   r_o_len;
    logic               r_o_ovf;

    t_need_req          need_req;
    t_need              need_q;
    t_need              alu_new;
    logic               alu_inc;
    logic               alu_old_zero;
    logic               alu_new_zero;

    logic               text_we;
    logic               text_re;
    logic [TXT_AW-1:0]  text_ra;
    t_code              text_q;

    logic               in_acc;
    logic               out_free;
    logic               room;
    logic               win_open;
    logic [CNT_W-1:0]   win_len;
    logic               load_out;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign room     = (r_right < CNT_W'(MAX_TEXT));
    assign win_open = r_pat_seen && (r_missing == '0) && (r_left < r_right);
    assign win_len  = r_right - r_left;

    mcw_need_ram u_need (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (need_req),
        .o_rd_data (need_q)
    );

    mcw_need_alu u_alu (
        .i_old      (need_q),
        .i_inc      (alu_inc),
        .o_new      (alu_new),
        .o_old_zero (alu_old_zero),
        .o_new_zero (alu_new_zero)
    );

    mcw_text_ram u_text (
        .i_clk     (i_clk),
        .i_wr_en   (text_we),
        .i_wr_addr (r_right[TXT_AW-1:0]),
        .i_wr_data (to_code(i_ch)),
        .i_rd_en   (text_re),
        .i_rd_addr (text_ra),
        .o_rd_data (text_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_op == OP_TEXT && !room) ? S_DONE : S_UPD;
                end
            end
            S_UPD:   n_state = (r_op == OP_PAT) ? S_IDLE : S_CHK;
            S_CHK:   n_state = win_open ? S_RDTXT : S_DONE;
            S_RDTXT: n_state = S_REM;
            S_REM:   n_state = S_CHK;
            S_DONE: begin
                if (!r_last || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        need_req = '0;
        text_we  = 1'b0;
        text_re  = 1'b0;
        text_ra  = r_left[TXT_AW-1:0];
        load_out = 1'b0;
        alu_inc  = (r_state == S_REM) || (r_op == OP_PAT);
        case (r_state)
            S_IDLE: begin
                need_req.rd_en   = in_acc;
                need_req.rd_addr = to_code(i_ch);
                text_we          = in_acc && (i_op == OP_TEXT) && room;
            end
            S_UPD: begin
                need_req.wr_en   = 1'b1;
                need_req.wr_addr = r_code;
                need_req.wr_data = alu_new;
            end
            S_CHK: begin
                text_re = win_open;
            end
            S_RDTXT: begin
                need_req.rd_en   = 1'b1;
                need_req.rd_addr = text_q;
            end
            S_REM: begin
                // text_q still holds the code of the character leaving the window
                need_req.wr_en   = 1'b1;
                need_req.wr_addr = text_q;
                need_req.wr_data = alu_new;
            end
            S_DONE: begin
                load_out     = r_last && out_free;
                need_req.clr = r_last && out_free;
            end
            default: begin
                need_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_op;
            r_code <= to_code(i_ch);
            r_last <= i_last;
        end
        if (load_out) begin
            r_o_found <= r_have_best;
            r_o_start <= r_have_best ? r_best_start : '0;
            r_o_len   <= r_have_best ? r_best_len : '0;
            r_o_ovf   <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_missing    <= '0;
            r_right      <= '0;
            r_left       <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_have_best  <= 1'b0;
            r_ovf        <= 1'b0;
            r_pat_seen   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_IDLE && in_acc && i_op == OP_TEXT && !room) begin
                r_ovf <= 1'b1;
            end

            if (r_state == S_UPD) begin
                if (r_op == OP_PAT) begin
                    r_pat_seen <= 1'b1;
                    if (alu_old_zero) begin
                        r_missing <= r_missing + MISS_W'(1);
                    end
                end else begin
                    r_right <= r_right + CNT_W'(1);
                    if (alu_new_zero && r_missing != '0) begin
                        r_missing <= r_missing - MISS_W'(1);
                    end
                end
            end

            // strict compare keeps the earliest of equal-length windows
            if (r_state == S_CHK && win_open && (!r_have_best || win_len < r_best_len)) begin
                r_have_best  <= 1'b1;
                r_best_start <= r_left[TXT_AW-1:0];
                r_best_len   <= win_len;
            end

            if (r_state == S_REM) begin
                r_left <= r_left + CNT_W'(1);
                if (alu_old_zero) begin
                    r_missing <= r_missing + MISS_W'(1);
                end
            end

            if (load_out) begin
                r_o_valid    <= 1'b1;
                r_missing    <= '0;
                r_right      <= '0;
                r_left       <= '0;
                r_best_start <= '0;
                r_best_len   <= '0;
                r_have_best  <= 1'b0;
                r_ovf        <= 1'b0;
                r_pat_seen   <= 1'b0;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_found     = r_o_found;
    assign o_start_res = r_o_start;
    assign o_length    = r_o_len;
    assign o_overflow  = r_o_ovf;

endmodule

@@ rtl/mcw_checker.sv @@
module mcw_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        i_op,
    input logic [mcw_pkg::CH_W-1:0]    i_ch,
    input logic                        i_last,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_found,
    input logic [mcw_pkg::TXT_AW-1:0]  o_start_res,
    input logic [mcw_pkg::CNT_W-1:0]   o_length,
    input logic                        o_overflow
);
    import mcw_pkg::*;

    // a waiting input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_op) && $stable(i_ch)
            && $stable(i_last))
        else $error("input word changed while waiting");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_start_res)
            && $stable(o_length) && $stable(o_overflow))
        else $error("result word changed while stalled");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_start_res == '0 && o_length == '0)
        else $error("not-found result carries a window");

    a_window_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_length != '0
            && (12'(o_start_res) + 12'(o_length)) <= 12'(MAX_TEXT))
        else $error("reported window lies outside the text buffer");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again before the previous word was processed");

endmodule

bind min_covering_window mcw_checker u_mcw_checker (.*);

@@ dv/min_covering_window_tb.sv @@
`timescale 1ns / 100ps

module min_covering_window_tb;
    import mcw_pkg::*;

    typedef struct {
        logic              found;
        logic [TXT_AW-1:0] start_pos;
        logic [CNT_W-1:0]  span;
        logic              ovf;
    } t_win;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_op;
    logic [CH_W-1:0]   i_ch;
    logic              i_last;
    logic              o_valid;
    logic              i_ready;
    logic              o_found;
    logic [TXT_AW-1:0] o_start_res;
    logic [CNT_W-1:0]  o_length;
    logic              o_overflow;

    min_covering_window dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_found     (o_found),
        .o_start_res (o_start_res),
        .o_length    (o_length),
        .o_overflow  (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // window tracker state
    t_need need_ctr [ALPHABET];
    t_code txt_buf [MAX_TEXT];
    int    miss_ctr;
    int    wr_pos;
    int    rd_pos;
    int    best_lo;
    int    best_len;
    bit    have_best;
    bit    ovf_seen_job;
    bit    pat_seen;

    t_win pending_wins [$];

    int errors      = 0;
    int words_sent  = 0;
    int wins_seen   = 0;
    int found_seen  = 0;
    int ovf_results = 0;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;
    int rx_gap  = 0;

    task automatic clear_job();
        for (int i = 0; i < ALPHABET; i++) need_ctr[i] = '0;
        miss_ctr     = 0;
        wr_pos       = 0;
        rd_pos       = 0;
        best_lo      = 0;
        best_len     = 0;
        have_best    = 1'b0;
        ovf_seen_job = 1'b0;
        pat_seen     = 1'b0;
    endtask

    task automatic track_word(input logic op, input logic [CH_W-1:0] ch, input logic last);
        t_code code;
        t_code gone;
        t_win  w;
        code = t_code'(ch % ALPHABET);
        if (op == OP_PAT) begin
            // last is ignored on a pattern word
            pat_seen = 1'b1;
            if (need_ctr[code] == 0) miss_ctr++;
            if (need_ctr[code] < NEED_MAX) need_ctr[code] += t_need'(1);
            return;
        end
        if (wr_pos >= MAX_TEXT) begin
            ovf_seen_job = 1'b1;
        end else begin
            txt_buf[wr_pos] = code;
            need_ctr[code] -= t_need'(1);
            if (need_ctr[code] == 0 && miss_ctr > 0) miss_ctr--;
            wr_pos++;
            // shrink from the left while the window still covers the pattern
            while (pat_seen && miss_ctr == 0 && rd_pos < wr_pos) begin
                if (!have_best || (wr_pos - rd_pos) < best_len) begin
                    have_best = 1'b1;
                    best_lo   = rd_pos;
                    best_len  = wr_pos - rd_pos;
                end
                gone = txt_buf[rd_pos];
                if (need_ctr[gone] == 0) miss_ctr++;
                need_ctr[gone] += t_need'(1);
                rd_pos++;
            end
        end
        if (last) begin
            w.found     = have_best;
            w.start_pos = have_best ? TXT_AW'(best_lo) : '0;
            w.span      = have_best ? CNT_W'(best_len) : '0;
            w.ovf       = ovf_seen_job;
            pending_wins.push_back(w);
            clear_job();
        end
    endtask

    task automatic send_word(input logic op, input logic [CH_W-1:0] ch, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_ch    <= ch;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        track_word(op, ch, last);
    endtask

    function automatic void cmp_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            if (errors <= 50)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_win w;
        if (i_rst_n && o_valid && i_ready) begin
            wins_seen++;
            if (o_found) found_seen++;
            if (o_overflow) ovf_results++;
            if (pending_wins.size() == 0) begin
                errors++;
                if (errors <= 50)
                    $display({"%0t: unexpected result, expected none, ",
                              "actual found %0b start %0d length %0d overflow %0b"},
                             $time, o_found, o_start_res, o_length, o_overflow);
            end else begin
                w = pending_wins.pop_front();
                cmp_field("found", 32'(w.found), 32'(o_found));
                cmp_field("start_res", 32'(w.start_pos), 32'(o_start_res));
                cmp_field("length", 32'(w.span), 32'(o_length));
                cmp_field("overflow", 32'(w.ovf), 32'(o_overflow));
            end
        end
    end

    // result receiver: random stalls after each word while rx_idle is set, plus long hold-offs on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_ready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (i_ready && o_valid) rx_gap = rx_idle ? $urandom_range(0, 9) : 0;
            end
        end
    end

    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // ties: earliest shortest window wins
        send_word(OP_PAT, 7'd0, 1'b0);
        send_word(OP_PAT, 7'd127, 1'b0);
        send_word(OP_TEXT, 7'd5, 1'b0);
        send_word(OP_TEXT, 7'd0, 1'b0);
        send_word(OP_TEXT, 7'd127, 1'b0);
        send_word(OP_TEXT, 7'd0, 1'b0);
        send_word(OP_TEXT, 7'd127, 1'b1);
        // empty pattern never finds a window
        send_word(OP_TEXT, 7'h55, 1'b0);
        send_word(OP_TEXT, 7'h2A, 1'b1);
        // last flag on a pattern word is ignored
        send_word(OP_PAT, 7'd42, 1'b1);
        send_word(OP_TEXT, 7'd42, 1'b0);
        send_word(OP_TEXT, 7'd42, 1'b1);
        // pattern words between text words
        send_word(OP_PAT, 7'd9, 1'b0);
        send_word(OP_TEXT, 7'd9, 1'b0);
        send_word(OP_PAT, 7'd10, 1'b0);
        send_word(OP_TEXT, 7'd10, 1'b0);
        send_word(OP_TEXT, 7'd9, 1'b1);
        // repeated pattern code not covered
        send_word(OP_PAT, 7'd1, 1'b0);
        send_word(OP_PAT, 7'd1, 1'b0);
        send_word(OP_TEXT, 7'd1, 1'b1);
    endtask

    task automatic test_need_saturation();
        tx_idle = 1'b0;
        repeat (2050) send_word(OP_PAT, 7'h41, 1'b0);
        send_word(OP_PAT, 7'h2A, 1'b0);
        send_word(OP_TEXT, 7'h2A, 1'b0);
        send_word(OP_TEXT, 7'h41, 1'b1);
    endtask

    task automatic test_long_text();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        // window spanning the whole buffer
        send_word(OP_PAT, 7'd5, 1'b0);
        send_word(OP_PAT, 7'd6, 1'b0);
        send_word(OP_TEXT, 7'd5, 1'b0);
        repeat (MAX_TEXT - 2) send_word(OP_TEXT, 7'($urandom_range(64, 127)), 1'b0);
        send_word(OP_TEXT, 7'd6, 1'b1);
        // window at the last slot, then dropped words past capacity
        send_word(OP_PAT, 7'd7, 1'b0);
        repeat (MAX_TEXT - 1) send_word(OP_TEXT, 7'($urandom_range(64, 127)), 1'b0);
        send_word(OP_TEXT, 7'd7, 1'b0);
        repeat (5) send_word(OP_TEXT, 7'($urandom_range(0, 127)), 1'b0);
        send_word(OP_TEXT, 7'd7, 1'b1);
        rx_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        tx_idle = 1'b0;
        rx_hold = 400;
        repeat (6) begin
            a = 7'($urandom_range(0, 127));
            b = 7'($urandom_range(0, 127));
            send_word(OP_PAT, a, 1'b0);
            send_word(OP_PAT, b, 1'b0);
            send_word(OP_TEXT, b, 1'b0);
            send_word(OP_TEXT, 7'($urandom_range(0, 127)), 1'b0);
            send_word(OP_TEXT, a, 1'b1);
        end
        tx_idle = 1'b1;
    endtask

    task automatic test_random_jobs();
        logic [CH_W-1:0] alpha [6];
        logic [CH_W-1:0] c;
        int k;
        int kind;
        int txt_len;
        int n0;
        n0 = words_sent;
        while (words_sent - n0 < 1800) begin
            if ($urandom_range(0, 7) == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise: any op, any code, any last
                repeat ($urandom_range(1, 10))
                    send_word(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                              $urandom_range(0, 3) == 0);
            end else begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++) alpha[i] = 7'($urandom_range(0, 127));
                if (kind != 1)
                    repeat ($urandom_range(1, 5))
                        send_word(OP_PAT, alpha[$urandom_range(0, k - 1)],
                                  $urandom_range(0, 7) == 0);
                txt_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 40);
                for (int i = 0; i < txt_len; i++) begin
                    if ($urandom_range(0, 29) == 0)
                        send_word(OP_PAT, alpha[$urandom_range(0, k - 1)], 1'b0);
                    c = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                    : alpha[$urandom_range(0, k - 1)];
                    send_word(OP_TEXT, c, i == txt_len - 1);
                end
            end
        end
    endtask

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op    = OP_PAT;
        i_ch    = '0;
        i_last  = 1'b0;
        clear_job();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_need_saturation();
        test_long_text();
        test_backpressure();
        test_random_jobs();
        i_valid <= 1'b0;

        for (int n = 0; n < 200000 && pending_wins.size() != 0; n++) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (pending_wins.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_wins.size());
        end

        $display("Sent %0d words; %0d job results checked, %0d with a window, %0d overflowed.",
                 words_sent, wins_seen, found_seen, ovf_results);
        $display("Covered ties, empty pattern, need saturation, full buffer and output stall.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
